### hdl/uhb_pkg.sv
package uhb_pkg;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_HIGH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_WIDTH     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINS_IN_USE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SCAN_BINS = 3'd4;

   localparam logic signed [31:0] RANGE_LOW_RESET     = 32'sd0;
   localparam logic signed [31:0] RANGE_HIGH_RESET    = 32'sd0;
   localparam logic [30:0]        BIN_WIDTH_RESET     = 31'd1;
   localparam logic [6:0]         BINS_IN_USE_RESET   = 7'd64;
   localparam logic [6:0]         MAX_SCAN_BINS_RESET = 7'd64;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               dataset_last;
   } req_type;

   typedef struct packed {
      logic        binned;
      logic [5:0]  bin_index;
      logic [15:0] bin_total;
      logic [15:0] max_total;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic hit;
   } loc_ctl_type;

endpackage

### hdl/uhb_locate.sv
module uhb_locate #(
   parameter int IDX_W    = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  uhb_pkg::req_type      in_data,
   input  logic signed [31:0]    range_low,
   input  logic signed [31:0]    range_high,
   input  logic [30:0]           bin_width,
   input  logic [IDX_W:0]        nb_eff,
   output uhb_pkg::loc_ctl_type  loc_ctl,
   output logic [IDX_W-1:0]      loc_idx
);

   localparam int DW = 32 + IDX_W;

   typedef struct packed {
      logic        valid;
      logic        last;
      logic        eq;
      logic        neg;
      logic [31:0] rem;
   } front_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic             eq;
      logic             miss;
      logic [31:0]      rem;
      logic [IDX_W-1:0] q;
   } stage_type;

   front_type        front_ff;
   front_type        front_in;
   stage_type        st_ff [IDX_W+1];
   stage_type        st_in [IDX_W+1];
   logic [32:0]      diff;
   logic [DW-1:0]    top_limit;
   logic [IDX_W-1:0] last_bin;

   always_comb begin
      diff           = {in_data.sample[31], in_data.sample} - {range_low[31], range_low};
      front_in.valid = in_valid;
      front_in.last  = in_data.dataset_last;
      front_in.eq    = (in_data.sample == range_high);
      front_in.neg   = diff[32];
      front_in.rem   = diff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else begin
         front_ff <= front_in;
      end
   end

   // Quotients at or beyond the index range can never name a bin in use.
   always_comb begin
      top_limit      = DW'(bin_width) << IDX_W;
      st_in[0].valid = front_ff.valid;
      st_in[0].last  = front_ff.last;
      st_in[0].eq    = front_ff.eq;
      st_in[0].miss  = front_ff.neg || (bin_width == '0) || (DW'(front_ff.rem) >= top_limit);
      st_in[0].rem   = front_ff.rem;
      st_in[0].q     = '0;
   end

   for (genvar j = 0; j < IDX_W; j++) begin : g_div
      localparam int K = IDX_W - 1 - j;
      logic [DW-1:0] div_sh;
      logic [DW-1:0] rem_ext;
      logic [DW-1:0] rem_sub;

      always_comb begin
         div_sh      = DW'(bin_width) << K;
         rem_ext     = DW'(st_ff[j].rem);
         rem_sub     = rem_ext - div_sh;
         st_in[j+1]  = st_ff[j];
         if (rem_ext >= div_sh) begin
            st_in[j+1].rem  = rem_sub[31:0];
            st_in[j+1].q[K] = 1'b1;
         end
      end
   end

   for (genvar s = 0; s <= IDX_W; s++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[s].valid <= 1'b0;
         end else begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   always_comb begin
      last_bin      = IDX_W'(nb_eff - 1'b1);
      loc_ctl.valid = st_ff[IDX_W].valid;
      loc_ctl.last  = st_ff[IDX_W].last;
      loc_ctl.hit   = 1'b0;
      loc_idx       = '0;
      priority if (!st_ff[IDX_W].miss && ({1'b0, st_ff[IDX_W].q} < nb_eff)) begin
         loc_ctl.hit = 1'b1;
         loc_idx     = st_ff[IDX_W].q;
      end else if (st_ff[IDX_W].eq) begin
         loc_ctl.hit = 1'b1;
         loc_idx     = last_bin;
      end else begin
         loc_ctl.hit = 1'b0;
         loc_idx     = '0;
      end
   end

endmodule

### hdl/uhb_count.sv
module uhb_count #(
   parameter int NUM_BINS   = 64,
   parameter int COUNT_BITS = 16,
   parameter int IDX_W      = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  uhb_pkg::loc_ctl_type loc_ctl,
   input  logic [IDX_W-1:0]     loc_idx,
   input  logic [IDX_W:0]       scan,
   output logic                 res_valid,
   output uhb_pkg::rsp_type     res_data
);

   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] mem [NUM_BINS];
   logic [COUNT_BITS-1:0] rd_ff;
   logic [NUM_BINS-1:0]   vbits_ff;
   logic [NUM_BINS-1:0]   vbits_in;
   uhb_pkg::loc_ctl_type  a_ctl_ff;
   logic [IDX_W-1:0]      a_idx_ff;
   logic                  vbit_ff;
   logic                  vbit_in;
   logic                  fwd_ff;
   logic                  fwd_in;
   logic [COUNT_BITS-1:0] fwd_data_ff;
   logic [COUNT_BITS-1:0] max_ff;
   logic [COUNT_BITS-1:0] max_in;
   logic [COUNT_BITS-1:0] cur;
   logic [COUNT_BITS-1:0] new_cnt;
   logic                  a_write;
   logic [31:0]           idx32;
   logic [31:0]           cnt32;
   logic [31:0]           max32;

   assign a_write = a_ctl_ff.valid && a_ctl_ff.hit;

   always_ff @(posedge clock) begin
      rd_ff <= mem[loc_idx];
      if (a_write) begin
         mem[a_idx_ff] <= new_cnt;
      end
   end

   // The sample now in the update stage writes at the same edge at which the
   // next one reads, so its count is forwarded and a dataset end voids the read.
   always_comb begin
      vbit_in = vbits_ff[loc_idx] && !(a_ctl_ff.valid && a_ctl_ff.last);
      fwd_in  = a_write && !a_ctl_ff.last && (loc_idx == a_idx_ff);
   end

   always_comb begin
      priority if (fwd_ff) begin
         cur = fwd_data_ff;
      end else if (vbit_ff) begin
         cur = rd_ff;
      end else begin
         cur = '0;
      end
      new_cnt = (cur == CMAX) ? cur : COUNT_BITS'(cur + 1'b1);
   end

   always_comb begin
      max_in = max_ff;
      if (a_write && ({1'b0, a_idx_ff} < scan) && (new_cnt > max_ff)) begin
         max_in = new_cnt;
      end
      vbits_in = vbits_ff;
      if (a_ctl_ff.valid && a_ctl_ff.last) begin
         vbits_in = '0;
      end else if (a_write) begin
         vbits_in[a_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         vbits_ff <= '0;
         max_ff   <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         a_ctl_ff <= loc_ctl;
         vbits_ff <= vbits_in;
         max_ff   <= max_in;
         fwd_ff   <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      a_idx_ff    <= loc_idx;
      vbit_ff     <= vbit_in;
      fwd_data_ff <= new_cnt;
   end

   always_comb begin
      idx32              = 32'(a_idx_ff);
      cnt32              = 32'(new_cnt);
      max32              = 32'(max_in);
      res_valid          = a_ctl_ff.valid;
      res_data.binned    = a_ctl_ff.hit;
      res_data.bin_index = a_ctl_ff.hit ? idx32[5:0] : 6'd0;
      res_data.bin_total = a_ctl_ff.hit ? cnt32[15:0] : 16'd0;
      res_data.max_total = max32[15:0];
   end

endmodule

### hdl/uhb_fifo.sv
module uhb_fifo #(
   parameter int DEPTH = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  uhb_pkg::rsp_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output uhb_pkg::rsp_type rd_data,
   output logic             full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   uhb_pkg::rsp_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             pop;

   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      count_in = CNT_W'(count_ff + CNT_W'(wr_valid) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### hdl/uniform_histogram_binner.sv
// A word reaches rsp_valid via the front register, division stages, count update stage
// and result queue; the bin search takes one restoring division step per index bit.
// Throughput: one word per cycle while queue credits remain, set by the count memory's
// read-modify-write, which forwards between back-to-back samples of the same bin.
// Reset is synchronous: control and CSR registers take their defaults, all bin counts
// read as zero at once via per-bin valid flags, the maximum clears, no clearing pass runs.
module uniform_histogram_binner #(
   parameter int NUM_BINS   = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  uhb_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output uhb_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [uhb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_data
);

   localparam int IDX_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int FIFO_DEPTH = IDX_W + 5;
   localparam int CRED_W     = $clog2(FIFO_DEPTH + 1);

   logic signed [31:0]   range_low_ff;
   logic signed [31:0]   range_high_ff;
   logic [30:0]          bin_width_ff;
   logic [6:0]           bins_in_use_ff;
   logic [6:0]           max_scan_bins_ff;
   logic [31:0]          biu32;
   logic [31:0]          nb32;
   logic [31:0]          msb32;
   logic [31:0]          scan32;
   logic [IDX_W:0]       nb_eff;
   logic [IDX_W:0]       scan;
   logic                 req_acc;
   logic                 rsp_acc;
   logic [CRED_W-1:0]    credits_ff;
   logic [CRED_W-1:0]    credits_in;
   uhb_pkg::loc_ctl_type loc_ctl;
   logic [IDX_W-1:0]     loc_idx;
   logic                 res_valid;
   uhb_pkg::rsp_type     res_data;
   logic                 fifo_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff     <= uhb_pkg::RANGE_LOW_RESET;
         range_high_ff    <= uhb_pkg::RANGE_HIGH_RESET;
         bin_width_ff     <= uhb_pkg::BIN_WIDTH_RESET;
         bins_in_use_ff   <= uhb_pkg::BINS_IN_USE_RESET;
         max_scan_bins_ff <= uhb_pkg::MAX_SCAN_BINS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            uhb_pkg::CSR_RANGE_LOW:     range_low_ff     <= csr_data;
            uhb_pkg::CSR_RANGE_HIGH:    range_high_ff    <= csr_data;
            uhb_pkg::CSR_BIN_WIDTH:     bin_width_ff     <= csr_data[30:0];
            uhb_pkg::CSR_BINS_IN_USE:   bins_in_use_ff   <= csr_data[6:0];
            uhb_pkg::CSR_MAX_SCAN_BINS: max_scan_bins_ff <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      biu32 = 32'(bins_in_use_ff);
      msb32 = 32'(max_scan_bins_ff);
      priority if (biu32 == 32'd0) begin
         nb32 = 32'd1;
      end else if (biu32 > 32'(NUM_BINS)) begin
         nb32 = 32'(NUM_BINS);
      end else begin
         nb32 = biu32;
      end
      scan32 = (msb32 < nb32) ? msb32 : nb32;
      nb_eff = (IDX_W + 1)'(nb32);
      scan   = (IDX_W + 1)'(scan32);
   end

   // Every accepted word holds a queue slot until it is delivered.
   assign req_ready = (credits_ff < CRED_W'(FIFO_DEPTH));
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;

   always_comb begin
      credits_in = CRED_W'(credits_ff + CRED_W'(req_acc) - CRED_W'(rsp_acc));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credits_ff <= '0;
      end else begin
         credits_ff <= credits_in;
      end
   end

   uhb_locate #(
      .IDX_W    (IDX_W)
   ) u_locate (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_acc),
      .in_data    (req_data),
      .range_low  (range_low_ff),
      .range_high (range_high_ff),
      .bin_width  (bin_width_ff),
      .nb_eff     (nb_eff),
      .loc_ctl    (loc_ctl),
      .loc_idx    (loc_idx)
   );

   uhb_count #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .loc_ctl   (loc_ctl),
      .loc_idx   (loc_idx),
      .scan      (scan),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   uhb_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (res_valid),
      .wr_data  (res_data),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_data  (rsp_data),
      .full     (fifo_full)
   );

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credits_ff <= CRED_W'(FIFO_DEPTH))
      else $error("credit count exceeds queue depth");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (credits_ff != '0))
      else $error("response word without an accepted request");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !fifo_full)
      else $error("result written into a full queue");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (loc_ctl.valid && loc_ctl.hit) |-> ({1'b0, loc_idx} < nb_eff))
      else $error("bin index beyond bins in use");

endmodule

### tb/sv/tb_uniform_histogram_binner.sv
`timescale 1ns / 1ps

module tb_uniform_histogram_binner;

   localparam int NUM_BINS = 64;
   localparam int NUM_DIR_ROWS = 37;
   localparam int RANDOM_PHASES = 6;
   localparam int WORDS_PER_PHASE = 100;
   localparam int FINAL_WORDS = 80;
   localparam logic [uhb_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   typedef enum logic [1:0] {ROW_CSR, ROW_PREDICTED, ROW_FIXED} dir_kind_type;

   typedef struct {
      dir_kind_type                    kind;
      logic [uhb_pkg::CSR_INDEX_W-1:0] index;
      logic [31:0]                     value;
      logic                            last;
      uhb_pkg::rsp_type                want;
   } dir_row_type;

   typedef struct {
      logic             typed;
      uhb_pkg::rsp_type want;
   } typed_rsp_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   uhb_pkg::req_type                req_data;
   logic                            rsp_valid;
   logic                            rsp_ready;
   uhb_pkg::rsp_type                rsp_data;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [uhb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [31:0]                     csr_data;

   bit stall_en = 1'b1;
   int mismatch_count = 0;

   longint      cfg_low;
   longint      cfg_high;
   longint      cfg_width;
   int          cfg_bins;
   int          cfg_scan;
   logic [15:0] hist_counts [NUM_BINS];
   logic [15:0] peak_count;

   uhb_pkg::rsp_type bin_results_q [$];
   typed_rsp_type    typed_q [$];

   longint      gen_low;
   longint      gen_width;
   int          gen_nb;
   logic [31:0] gen_high;

   dir_row_type dir_rows [NUM_DIR_ROWS];

   uniform_histogram_binner u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic uhb_pkg::rsp_type bin_sample(input uhb_pkg::req_type w);
      longint           v;
      longint           d;
      longint           q;
      int               nb;
      int               scan;
      int               b;
      logic             hit;
      uhb_pkg::rsp_type r;
      v = $signed(w.sample);
      nb = (cfg_bins == 0) ? 1 : ((cfg_bins > NUM_BINS) ? NUM_BINS : cfg_bins);
      scan = (cfg_scan < nb) ? cfg_scan : nb;
      hit = 1'b0;
      b = 0;
      if (cfg_width != 0 && v >= cfg_low) begin
         d = v - cfg_low;
         q = d / cfg_width;
         if (q < nb) begin
            hit = 1'b1;
            b = int'(q);
         end
      end
      if (!hit && v == cfg_high) begin
         hit = 1'b1;
         b = nb - 1;
      end
      r = '0;
      if (hit) begin
         if (hist_counts[b] != 16'hFFFF) begin
            hist_counts[b] = hist_counts[b] + 16'd1;
         end
         r.binned = 1'b1;
         r.bin_index = b[5:0];
         r.bin_total = hist_counts[b];
         if (b < scan && hist_counts[b] > peak_count) begin
            peak_count = hist_counts[b];
         end
      end
      r.max_total = peak_count;
      if (w.dataset_last) begin
         foreach (hist_counts[i]) hist_counts[i] = '0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      typed_rsp_type    pending;
      uhb_pkg::rsp_type predicted;
      uhb_pkg::rsp_type want;
      if (reset) begin
         cfg_low = uhb_pkg::RANGE_LOW_RESET;
         cfg_high = uhb_pkg::RANGE_HIGH_RESET;
         cfg_width = longint'(uhb_pkg::BIN_WIDTH_RESET);
         cfg_bins = int'(uhb_pkg::BINS_IN_USE_RESET);
         cfg_scan = int'(uhb_pkg::MAX_SCAN_BINS_RESET);
         foreach (hist_counts[i]) hist_counts[i] = '0;
         peak_count = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               uhb_pkg::CSR_RANGE_LOW:     cfg_low = $signed(csr_data);
               uhb_pkg::CSR_RANGE_HIGH:    cfg_high = $signed(csr_data);
               uhb_pkg::CSR_BIN_WIDTH:     cfg_width = longint'(csr_data[30:0]);
               uhb_pkg::CSR_BINS_IN_USE:   cfg_bins = int'(csr_data[6:0]);
               uhb_pkg::CSR_MAX_SCAN_BINS: cfg_scan = int'(csr_data[6:0]);
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pending = typed_q.pop_front();
            predicted = bin_sample(req_data);
            bin_results_q.insert(bin_results_q.size(),
                                 pending.typed ? pending.want : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (bin_results_q.size() == 0) begin
               $error("result word with no expectation waiting");
               mismatch_count++;
            end else begin
               want = bin_results_q.pop_front();
               if (rsp_data.binned !== want.binned) begin
                  $error("binned: expected %0d, actual %0d", want.binned, rsp_data.binned);
                  mismatch_count++;
               end
               if (rsp_data.bin_index !== want.bin_index) begin
                  $error("bin_index: expected %0d, actual %0d",
                         want.bin_index, rsp_data.bin_index);
                  mismatch_count++;
               end
               if (rsp_data.bin_total !== want.bin_total) begin
                  $error("bin_total: expected %0d, actual %0d",
                         want.bin_total, rsp_data.bin_total);
                  mismatch_count++;
               end
               if (rsp_data.max_total !== want.max_total) begin
                  $error("max_total: expected %0d, actual %0d",
                         want.max_total, rsp_data.max_total);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_en && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic dir_row_type csr_row(input logic [uhb_pkg::CSR_INDEX_W-1:0] index,
                                           input logic [31:0] value);
      dir_row_type r;
      r = '{kind: ROW_CSR, index: index, value: value, last: 1'b0, want: '0};
      return r;
   endfunction

   function automatic dir_row_type word_row(input logic [31:0] value, input logic last);
      dir_row_type r;
      r = '{kind: ROW_PREDICTED, index: '0, value: value, last: last, want: '0};
      return r;
   endfunction

   function automatic dir_row_type fixed_row(input logic [31:0] value, input logic last,
                                             input logic binned, input logic [5:0] index,
                                             input logic [15:0] total,
                                             input logic [15:0] maxv);
      dir_row_type r;
      r = '{kind: ROW_FIXED, index: '0, value: value, last: last,
            want: uhb_pkg::rsp_type'{binned, index, total, maxv}};
      return r;
   endfunction

   task automatic send_word(input logic [31:0] value, input logic last,
                            input logic typed, input uhb_pkg::rsp_type want);
      if (stall_en && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      typed_q.insert(typed_q.size(), '{typed: typed, want: want});
      req_valid <= 1'b1;
      req_data <= uhb_pkg::req_type'{sample: value, dataset_last: last};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bin_results_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [uhb_pkg::CSR_INDEX_W-1:0] index,
                            input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic randomize_config();
      longint unsigned span;
      int              nb_raw;
      int              scan_raw;
      case ($urandom_range(0, 7))
         0: nb_raw = 1;
         1: nb_raw = 0;
         2: nb_raw = $urandom_range(65, 127);
         3: nb_raw = NUM_BINS;
         default: nb_raw = $urandom_range(1, NUM_BINS);
      endcase
      case ($urandom_range(0, 5))
         0: scan_raw = 0;
         1: scan_raw = $urandom_range(65, 127);
         2: scan_raw = NUM_BINS;
         default: scan_raw = $urandom_range(0, NUM_BINS);
      endcase
      gen_nb = (nb_raw == 0) ? 1 : ((nb_raw > NUM_BINS) ? NUM_BINS : nb_raw);
      case ($urandom_range(0, 9))
         0: gen_width = 0;
         1: gen_width = longint'($urandom() & 32'h7FFF_FFFF);
         default: gen_width = $urandom_range(1, 1 << $urandom_range(0, 24));
      endcase
      if ($urandom_range(0, 4) != 0 && gen_width * gen_nb < 64'h1_0000_0000) begin
         span = 64'h1_0000_0000 - longint'(gen_width * gen_nb);
         gen_low = -64'sh8000_0000 + longint'({$urandom(), $urandom()} % span);
      end else begin
         gen_low = $signed($urandom());
      end
      case ($urandom_range(0, 9))
         6, 7: gen_high = $urandom();
         8: gen_high = gen_low[31:0];
         9: gen_high = gen_low[31:0] - 32'd1;
         default: gen_high = 32'(gen_low + gen_width * gen_nb);
      endcase
      write_csr(uhb_pkg::CSR_RANGE_LOW, gen_low[31:0]);
      write_csr(uhb_pkg::CSR_RANGE_HIGH, gen_high);
      write_csr(uhb_pkg::CSR_BIN_WIDTH, {1'($urandom_range(0, 1)), gen_width[30:0]});
      write_csr(uhb_pkg::CSR_BINS_IN_USE, 32'(nb_raw));
      write_csr(uhb_pkg::CSR_MAX_SCAN_BINS, 32'(scan_raw));
   endtask

   function automatic logic [31:0] pick_sample();
      longint v;
      longint off;
      int     b;
      case ($urandom_range(0, 15))
         10, 11: return gen_high;
         12: v = gen_low - 1;
         13: v = gen_low + gen_width * gen_nb;
         14, 15: return $urandom();
         default: begin
            if ($urandom_range(0, 1) == 1) begin
               b = $urandom_range(0, gen_nb - 1);
            end else begin
               b = $urandom_range(0, (gen_nb < 4) ? gen_nb - 1 : 3);
            end
            case ($urandom_range(0, 3))
               0: off = 0;
               1: off = gen_width - 1;
               default: off = (gen_width == 0) ? 0 : longint'($urandom()) % gen_width;
            endcase
            v = gen_low + gen_width * b + off;
         end
      endcase
      return v[31:0];
   endfunction

   initial begin
      int          p;
      int          i;
      dir_row_type row;
      logic [31:0] sample;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      dir_rows = '{
         fixed_row(32'h0000_0000, 1'b0, 1'b1, 6'd0, 16'd1, 16'd1),
         fixed_row(32'h0000_0000, 1'b1, 1'b1, 6'd0, 16'd2, 16'd2),
         fixed_row(32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0, 16'd0, 16'd2),
         fixed_row(32'h0000_003F, 1'b0, 1'b1, 6'd63, 16'd1, 16'd2),
         fixed_row(32'h0000_0040, 1'b0, 1'b0, 6'd0, 16'd0, 16'd2),
         fixed_row(32'h7FFF_FFFF, 1'b0, 1'b0, 6'd0, 16'd0, 16'd2),
         fixed_row(32'h8000_0000, 1'b1, 1'b0, 6'd0, 16'd0, 16'd2),
         csr_row(uhb_pkg::CSR_RANGE_LOW, 32'h8000_0000),
         csr_row(uhb_pkg::CSR_RANGE_HIGH, 32'h7FFF_FFFF),
         csr_row(uhb_pkg::CSR_BIN_WIDTH, 32'h7FFF_FFFF),
         csr_row(uhb_pkg::CSR_BINS_IN_USE, 32'd2),
         csr_row(uhb_pkg::CSR_MAX_SCAN_BINS, 32'd1),
         word_row(32'h8000_0000, 1'b0),
         word_row(32'h7FFF_FFFE, 1'b0),
         word_row(32'h7FFF_FFFF, 1'b0),
         word_row(32'hFFFF_FFFF, 1'b0),
         word_row(32'hFFFF_FFFE, 1'b1),
         csr_row(uhb_pkg::CSR_BIN_WIDTH, 32'h8000_0000),
         csr_row(uhb_pkg::CSR_MAX_SCAN_BINS, 32'd0),
         word_row(32'h7FFF_FFFF, 1'b0),
         word_row(32'h8000_0000, 1'b0),
         word_row(32'h0000_0000, 1'b1),
         csr_row(uhb_pkg::CSR_BINS_IN_USE, 32'd0),
         csr_row(uhb_pkg::CSR_BIN_WIDTH, 32'h0000_0010),
         csr_row(uhb_pkg::CSR_RANGE_LOW, 32'h0000_0000),
         csr_row(uhb_pkg::CSR_RANGE_HIGH, 32'h0000_0010),
         csr_row(uhb_pkg::CSR_MAX_SCAN_BINS, 32'd127),
         word_row(32'h0000_000F, 1'b0),
         word_row(32'h0000_0010, 1'b0),
         word_row(32'h0000_0011, 1'b0),
         word_row(32'h0000_0000, 1'b0),
         csr_row(uhb_pkg::CSR_BINS_IN_USE, 32'd127),
         csr_row(CSR_SPARE, 32'hFFFF_FFFF),
         csr_row(uhb_pkg::CSR_RANGE_HIGH, 32'h8000_0000),
         word_row(32'h8000_0000, 1'b0),
         word_row(32'h0000_03FF, 1'b0),
         word_row(32'h0000_0400, 1'b1)
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIR_ROWS; i++) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            wait_drained();
            write_csr(row.index, row.value);
         end else begin
            send_word(row.value, row.last, row.kind == ROW_FIXED, row.want);
         end
      end

      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         stall_en = (p % 3 != 2);
         randomize_config();
         for (i = 0; i < WORDS_PER_PHASE; i++) begin
            send_word(pick_sample(), $urandom_range(0, 19) == 0, 1'b0, '0);
         end
      end

      // The run closes with a burst that has no idling on either side.
      wait_drained();
      stall_en = 1'b0;
      write_csr(uhb_pkg::CSR_RANGE_LOW, 32'h0000_0000);
      write_csr(uhb_pkg::CSR_RANGE_HIGH, 32'h0000_0040);
      write_csr(uhb_pkg::CSR_BIN_WIDTH, 32'h0000_0001);
      write_csr(uhb_pkg::CSR_BINS_IN_USE, 32'd64);
      write_csr(uhb_pkg::CSR_MAX_SCAN_BINS, 32'd64);
      for (i = 0; i < FINAL_WORDS; i++) begin
         sample = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(0, 70));
         send_word(sample, i == FINAL_WORDS - 1, 1'b0, '0);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

### sim.f
hdl/uhb_pkg.sv
hdl/uhb_locate.sv
hdl/uhb_count.sv
hdl/uhb_fifo.sv
hdl/uniform_histogram_binner.sv
tb/sv/tb_uniform_histogram_binner.sv
